/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned KEY_BITS     = 16;
  localparam int unsigned PAYLOAD_BITS = 16;
  localparam int unsigned COUNT_BITS   = 5;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     head_key;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [COUNT_BITS-1:0]   count;
  } spq_out_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic                    occ;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } spq_entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } spq_cmd_t;

endpackage

`default_nettype wire

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue built from a chain of cells.
// The queue holds up to DEPTH entries, each a key with a payload handle, in
// ascending key order; equal keys are served in arrival order.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries one
// operation per transaction: enqueue, dequeue head, peek head, or a no-op.
// The output channel (out_valid_o, out_stall_i, out_data_o) returns exactly
// one result transaction per operation, with status, head entry and count.
// The result is registered at the edge that accepts the operation. The queue
// takes one operation per cycle while the receiver does not stall, because
// every cell compares its own key against the broadcast key in parallel and
// moves one place left or right in the same cycle.
// When the receiver stalls, the result register holds its value and the
// input is stalled until that result is taken; a new operation is accepted
// in the same cycle the waiting result leaves.
// Reset empties the queue and drops any result waiting in the output
// register; the key and payload storage is not cleared, as only occupied
// cells are ever read.
// An enqueue to a full queue is dropped and flagged; a dequeue or peek of
// an empty queue is flagged and returns zero key and payload.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Count of held entries, kept alongside the occupancy bits of the cells.
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  spq_out_t        out_q, out_d;

  logic     accept;
  logic     full, empty;
  op_e      op;
  spq_cmd_t cmd;

  spq_entry_t entries [DEPTH];
  logic       keeps   [DEPTH];

  // A new operation may enter whenever the result register is free or its
  // contents leave in this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign op    = op_e'(in_data_i.operation);
  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign cmd.enq     = accept && (op == OP_ENQ) && !full;
  assign cmd.deq     = accept && (op == OP_DEQ) && !empty;
  assign cmd.key     = in_data_i.key;
  assign cmd.payload = in_data_i.payload;

  // The chain: cell zero holds the head. On insert each cell either keeps
  // its entry, takes the new one, or takes its left neighbor's entry. On
  // removal every cell takes its right neighbor's entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_entry;
    spq_entry_t right_entry;
    logic       left_keep;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_keep  = 1'b1;
    end else begin : g_inner_left
      assign left_entry = entries[i-1];
      assign left_keep  = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_right
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_entry),
      .left_keep_i (left_keep),
      .right_i     (right_entry),
      .entry_o     (entries[i]),
      .keep_o      (keeps[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Result formed from the head cell before it moves.
  always_comb begin
    out_d.status       = ST_OK;
    out_d.head_key     = '0;
    out_d.head_payload = '0;
    unique case (op)
      OP_ENQ: begin
        if (full) begin
          out_d.status = ST_FULL;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.head_key     = entries[0].key;
          out_d.head_payload = entries[0].payload;
        end
      end
      OP_NOP: begin
        out_d.status = ST_OK;
      end
      default: begin
        out_d.status = ST_OK;
      end
    endcase
    // The count field wraps when the queue is deeper than the field allows.
    out_d.count = COUNT_BITS'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* src/spq_cell.sv */
// One storage cell of the sorted priority queue chain.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_entry_t left_i,
  input  logic                left_keep_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic                keep_o
);
  import spq_pkg::*;

  logic                    occ_q, occ_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  // The cell keeps its entry on insert when it holds a key no larger than
  // the new one, so equal keys stay in arrival order.
  assign keep_o = occ_q && (key_q <= cmd_i.key);

  always_comb begin
    occ_d = occ_q;
    key_d = key_q;
    pay_d = pay_q;
    if (cmd_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          occ_d = 1'b1;
          key_d = cmd_i.key;
          pay_d = cmd_i.payload;
        end else begin
          occ_d = left_i.occ;
          key_d = left_i.key;
          pay_d = left_i.payload;
        end
      end
    end else if (cmd_i.deq) begin
      occ_d = right_i.occ;
      key_d = right_i.key;
      pay_d = right_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign entry_o = '{occ: occ_q, key: key_q, payload: pay_q};

endmodule

`default_nettype wire
